@@ hw/rtl/assert_macros.svh @@
// -----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks shared by the line generator RTL.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at every rising edge of clk outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that an expression never holds
`define ASSERT_NEVER(label, expr, msg) \
	`ASSERT_CLK(label, !(expr), msg)

`endif

@@ hw/rtl/blg_pkg.sv @@
// -----------------------------------------------------------------------------
// Line generator package
// Widths, request types and queue sizes shared by the line generator.
// -----------------------------------------------------------------------------
package blg_pkg;

	localparam int COORD_WIDTH = 11;
	localparam int INC_W       = COORD_WIDTH + 1;
	localparam int ACC_W       = COORD_WIDTH + 3;
	localparam int CQ_DEPTH    = 4;
	localparam int CQ_PTR_W    = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W    = CQ_PTR_W + 1;

	typedef logic [COORD_WIDTH-1:0] coord_t;
	typedef logic [INC_W-1:0]       inc_t;

	typedef enum logic {
		ACT_START = 1'b0,
		ACT_STEP  = 1'b1
	} action_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} color_t;

	typedef struct packed {
		action_t    action;
		coord_t     start_row;
		coord_t     start_col;
		coord_t     end_row;
		coord_t     end_col;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} in_req_t;

	typedef struct packed {
		coord_t     pixel_row;
		coord_t     pixel_col;
		logic [7:0] pixel_red;
		logic [7:0] pixel_green;
		logic [7:0] pixel_blue;
		logic       last_pixel;
	} out_req_t;

	typedef struct packed {
		coord_t major_pos;
		coord_t major_end;
		coord_t minor_pos;
		logic   minor_down;
		coord_t major_span;
		inc_t   error_inc;
		logic   is_steep;
		color_t color;
	} setup_t;

	typedef struct packed {
		action_t action;
		setup_t  setup;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

@@ hw/rtl/blg_front.sv @@
// -----------------------------------------------------------------------------
// Line generator front end
// Accepts requests, classifies them and precomputes the line setup of a start.
// -----------------------------------------------------------------------------
module blg_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  blg_pkg::in_req_t item,
	output logic            full,
	input  blg_pkg::q_stat_t cq_stat,
	output logic            cq_push,
	output blg_pkg::cmd_t   cq_data
);
	import blg_pkg::*;

	function automatic coord_t abs_diff(input coord_t a, input coord_t b);
		abs_diff = (a > b) ? (a - b) : (b - a);
	endfunction

	logic    accept;
	logic    steep;
	logic    valid_s1;
	action_t action_s1;
	coord_t  a0_s1, b0_s1, a1_s1, b1_s1;
	logic    steep_s1;
	color_t  color_s1;
	logic    swap;
	coord_t  near_a, near_b, far_a, far_b;

	assign full    = valid_s1 && cq_stat.full;
	assign accept  = push && !full;
	assign cq_push = valid_s1 && !cq_stat.full;
	assign steep   = abs_diff(item.start_row, item.end_row) < abs_diff(item.start_col, item.end_col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (cq_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= item.action;
			steep_s1  <= steep;
			a0_s1     <= steep ? item.start_col : item.start_row;
			b0_s1     <= steep ? item.start_row : item.start_col;
			a1_s1     <= steep ? item.end_col : item.end_row;
			b1_s1     <= steep ? item.end_row : item.end_col;
			color_s1  <= '{red: item.red, green: item.green, blue: item.blue};
		end
	end

	// order endpoints by major coordinate
	always_comb begin
		swap   = a0_s1 > a1_s1;
		near_a = swap ? a1_s1 : a0_s1;
		near_b = swap ? b1_s1 : b0_s1;
		far_a  = swap ? a0_s1 : a1_s1;
		far_b  = swap ? b0_s1 : b1_s1;
		cq_data.action           = action_s1;
		cq_data.setup.major_pos  = near_a;
		cq_data.setup.major_end  = far_a;
		cq_data.setup.minor_pos  = near_b;
		cq_data.setup.minor_down = far_b < near_b;
		cq_data.setup.major_span = far_a - near_a;
		cq_data.setup.error_inc  = {abs_diff(near_b, far_b), 1'b0};
		cq_data.setup.is_steep   = steep_s1;
		cq_data.setup.color      = color_s1;
	end

endmodule

@@ hw/rtl/blg_cmd_queue.sv @@
// -----------------------------------------------------------------------------
// Line generator command queue
// Short first-in first-out queue between the front end and the stepper.
// -----------------------------------------------------------------------------
module blg_cmd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  blg_pkg::cmd_t    wdata,
	input  logic             pop,
	output blg_pkg::cmd_t    rdata,
	output blg_pkg::q_stat_t stat
);
	import blg_pkg::*;

	cmd_t                mem_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_ptr_q;
	logic [CQ_PTR_W-1:0] rd_ptr_q;
	logic [CQ_CNT_W-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign stat.full  = count_q == CQ_CNT_W'(CQ_DEPTH);
	assign stat.empty = count_q == '0;
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rdata      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + CQ_PTR_W'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + CQ_PTR_W'(1);
			if (do_push && !do_pop) count_q <= count_q + CQ_CNT_W'(1);
			else if (do_pop && !do_push) count_q <= count_q - CQ_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end

endmodule

@@ hw/rtl/blg_back.sv @@
// -----------------------------------------------------------------------------
// Line generator stepper
// Holds the line state, steps the error term and buffers the pixels.
// -----------------------------------------------------------------------------
module blg_back (
	input  logic             clk,
	input  logic             arst_n,
	input  blg_pkg::q_stat_t cq_stat,
	input  blg_pkg::cmd_t    cq_data,
	output logic             cq_pop,
	input  logic             pop,
	output logic             empty,
	output blg_pkg::out_req_t pixel
);
	import blg_pkg::*;

	logic                    active_q;
	coord_t                  major_pos_q, major_end_q, minor_pos_q, span_q;
	logic                    minor_down_q;
	logic                    steep_q;
	inc_t                    inc_q;
	color_t                  color_q;
	logic signed [ACC_W-1:0] err_q, err_sum, err_next, inc_ext, span_ext;
	logic                    move;
	logic                    last;
	logic                    emit;
	logic                    out_take;
	out_req_t                pix;
	out_req_t                ob_q [2];
	logic                    ob_wr_q, ob_rd_q;
	logic [1:0]              ob_cnt_q;
	logic                    ob_full;

	assign ob_full  = ob_cnt_q == 2'd2;
	assign cq_pop   = !cq_stat.empty && !ob_full;
	assign emit     = cq_pop && cq_data.action == ACT_STEP && active_q;
	assign empty    = ob_cnt_q == 2'd0;
	assign out_take = pop && !empty;
	assign pixel    = ob_q[ob_rd_q];
	assign last     = major_pos_q == major_end_q;

	always_comb begin
		inc_ext  = signed'({{(ACC_W-INC_W){1'b0}}, inc_q});
		span_ext = signed'({{(ACC_W-COORD_WIDTH){1'b0}}, span_q});
		err_sum  = err_q + inc_ext;
		move     = err_sum > span_ext;
		err_next = move ? err_sum - (span_ext <<< 1) : err_sum;
		pix.pixel_row   = steep_q ? minor_pos_q : major_pos_q;
		pix.pixel_col   = steep_q ? major_pos_q : minor_pos_q;
		pix.pixel_red   = color_q.red;
		pix.pixel_green = color_q.green;
		pix.pixel_blue  = color_q.blue;
		pix.last_pixel  = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ob_wr_q  <= 1'b0;
			ob_rd_q  <= 1'b0;
			ob_cnt_q <= 2'd0;
		end else begin
			if (cq_pop) begin
				if (cq_data.action == ACT_START) active_q <= 1'b1;
				else if (active_q && last) active_q <= 1'b0;
			end
			if (emit) ob_wr_q <= ~ob_wr_q;
			if (out_take) ob_rd_q <= ~ob_rd_q;
			if (emit && !out_take) ob_cnt_q <= ob_cnt_q + 2'd1;
			else if (out_take && !emit) ob_cnt_q <= ob_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cq_pop && cq_data.action == ACT_START) begin
			major_pos_q  <= cq_data.setup.major_pos;
			major_end_q  <= cq_data.setup.major_end;
			minor_pos_q  <= cq_data.setup.minor_pos;
			minor_down_q <= cq_data.setup.minor_down;
			span_q       <= cq_data.setup.major_span;
			inc_q        <= cq_data.setup.error_inc;
			steep_q      <= cq_data.setup.is_steep;
			color_q      <= cq_data.setup.color;
			err_q        <= '0;
		end else if (emit && !last) begin
			err_q       <= err_next;
			major_pos_q <= major_pos_q + COORD_WIDTH'(1);
			if (move) begin
				minor_pos_q <= minor_down_q ? minor_pos_q - COORD_WIDTH'(1)
				                            : minor_pos_q + COORD_WIDTH'(1);
			end
		end
		if (emit) ob_q[ob_wr_q] <= pix;
	end

endmodule

@@ hw/rtl/bresenham_line_generator.sv @@
// -----------------------------------------------------------------------------
// Bresenham line generator
// Rasterises a line between two endpoints, one pixel per step request.
// -----------------------------------------------------------------------------
// Input channel: a request is taken on a rising edge with push high and full
// low. A start request loads both endpoints and the colour and gives no
// pixel; each step request then gives one pixel, both endpoints included,
// the final one flagged by last_pixel. A step with no line in progress gives
// nothing, and a start during a line replaces it.
// Result channel: while empty is low the oldest pixel sits on the pixel port
// and is taken on a rising edge with pop high.
// Path: a step request is registered in the front end, then held in the
// command queue and then in the pixel buffer before its pixel shows.
// Throughput: one request per cycle when not stalled, set by the stepper,
// which performs one error add, compare and coordinate increment per cycle.
// A four-entry command queue and a two-entry pixel buffer let either side
// stall; when pop stays low the buffer fills, the queue backs up and full
// rises. Reset empties both queues and ends any line in progress.
// -----------------------------------------------------------------------------
module bresenham_line_generator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  blg_pkg::in_req_t  item,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output blg_pkg::out_req_t pixel
);
	import blg_pkg::*;
	`include "assert_macros.svh"

	q_stat_t cq_stat;
	logic    cq_push;
	logic    cq_pop;
	cmd_t    cq_wdata;
	cmd_t    cq_rdata;

	blg_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item    (item),
		.full    (full),
		.cq_stat (cq_stat),
		.cq_push (cq_push),
		.cq_data (cq_wdata)
	);

	blg_cmd_queue u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cq_push),
		.wdata  (cq_wdata),
		.pop    (cq_pop),
		.rdata  (cq_rdata),
		.stat   (cq_stat)
	);

	blg_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cq_stat (cq_stat),
		.cq_data (cq_rdata),
		.cq_pop  (cq_pop),
		.pop     (pop),
		.empty   (empty),
		.pixel   (pixel)
	);

	`ASSERT_NEVER(a_cq_push_full, cq_push && cq_stat.full, "command pushed into full queue")
	`ASSERT_NEVER(a_cq_pop_empty, cq_pop && cq_stat.empty, "command popped from empty queue")
	`ASSERT_CLK(a_full_needs_queue, full |-> cq_stat.full, "full raised with room in queue")

endmodule
